// ===== hw/rtl/dks_pkg.sv =====
package dks_pkg;

  localparam int NUM_KEYS        = 8;
  localparam int TICK_COUNT_BITS = 16;
  localparam int PIN_W           = 8;
  localparam int TICK_REG_W      = 16;

  localparam logic [PIN_W-1:0] KEY_MASK =
    PIN_W'((64'd1 << NUM_KEYS) - 64'd1);
  localparam logic [31:0] COUNT_MAX =
    32'((64'd1 << TICK_COUNT_BITS) - 64'd1);

  typedef logic [TICK_COUNT_BITS-1:0] cnt_t;

  // event codes of a result word
  typedef enum logic [1:0] {
    EV_BUTTON = 2'd0,
    EV_SWITCH = 2'd1,
    EV_LONG   = 2'd2
  } event_kind_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_BOUNCE = 2'd0;
  localparam logic [1:0] REG_LONG   = 2'd1;
  localparam logic [1:0] REG_SWMASK = 2'd2;

  typedef struct packed {
    event_kind_t      kind;
    logic [PIN_W-1:0] down;
    logic [PIN_W-1:0] changed;
    logic             last;
  } word_t;

  // tick register to counter limit: zero acts as one, clipped to counter max
  function automatic cnt_t limit_of(input logic [TICK_REG_W-1:0] ticks);
    logic [31:0] w;
    w = 32'(ticks);
    if (w == 32'd0) begin
      w = 32'd1;
    end else if (w > COUNT_MAX) begin
      w = COUNT_MAX;
    end
    return TICK_COUNT_BITS'(w);
  endfunction

  // saturating increment
  function automatic cnt_t count_up(input cnt_t c);
    if (32'(c) == COUNT_MAX) begin
      return c;
    end
    return c + cnt_t'(1);
  endfunction

endpackage

// ===== hw/rtl/debounced_key_scanner.sv =====
// Debounced key scanner with long-press timer. Each input word is one time
// tick carrying eight active-low key pin levels; the block takes one tick per
// clock cycle while in_stall is low, and all debounce, scan and timer work for
// that tick is done in the same cycle. Events (long press, then button, then
// switch, at most three per tick, the final one marked by out_last) go into a
// four-word output queue; in_stall rises only while fewer than three queue
// words are free after this cycle's read. With the output free, a tick behind
// one that raised three events waits until at most one word is left, and
// longer while out_stall holds words in the queue. The user must write the
// registers over the APB-style port only while the block is idle; the block does not enforce this.
module debounced_key_scanner import dks_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // tick input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIN_W-1:0]      in_pin_levels,
  // event output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_event_kind,
  output logic [PIN_W-1:0]      out_keys_down,
  output logic [PIN_W-1:0]      out_keys_changed,
  output logic                  out_last,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // configuration registers
  logic [TICK_REG_W-1:0] bounce_ticks_r;
  logic [TICK_REG_W-1:0] long_ticks_r;
  logic [PIN_W-1:0]      switch_mask_r;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounce_ticks_r <= TICK_REG_W'(50);
      long_ticks_r   <= TICK_REG_W'(1000);
      switch_mask_r  <= PIN_W'(12);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_BOUNCE: bounce_ticks_r <= pwdata[TICK_REG_W-1:0];
        REG_LONG:   long_ticks_r   <= pwdata[TICK_REG_W-1:0];
        REG_SWMASK: switch_mask_r  <= pwdata[PIN_W-1:0];
        default:    ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_BOUNCE: prdata = 32'(bounce_ticks_r);
      REG_LONG:   prdata = 32'(long_ticks_r);
      REG_SWMASK: prdata = 32'(switch_mask_r);
      default:    prdata = 32'd0;
    endcase
  end

  // scanner state
  logic [PIN_W-1:0] prev_r, prev_nxt;
  logic             window_r, window_nxt;
  cnt_t             bcount_r, bcount_nxt;
  logic             first_r, first_nxt;
  logic [PIN_W-1:0] stable_r, stable_nxt;
  logic             lrun_r, lrun_nxt;
  cnt_t             lcount_r, lcount_nxt;
  logic             armed_r, armed_nxt;

  // output queue, four words
  word_t         q_r [4];
  logic [1:0]    wptr_r, rptr_r;
  logic [2:0]    qcnt_r;
  logic          pop, accept;
  logic [2:0]    after_pop;

  assign out_valid = (qcnt_r != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign after_pop = qcnt_r - 3'(pop);
  assign in_stall  = (after_pop > 3'd1);
  assign accept    = in_valid && !in_stall;

  // per-tick scan logic
  logic [PIN_W-1:0] keys, sw, pressed, released, changed;
  logic             v_long, v_btn, v_sw, scan, btn_pressed;
  cnt_t             lc_inc, bc_inc;

  always_comb begin
    keys     = (~in_pin_levels) & KEY_MASK;
    sw       = switch_mask_r & KEY_MASK;
    pressed  = keys & ~stable_r;
    released = stable_r & ~keys;
    changed  = keys ^ stable_r;
    btn_pressed = (pressed & ~sw) != '0;

    prev_nxt   = in_pin_levels;
    window_nxt = window_r;
    bcount_nxt = bcount_r;
    first_nxt  = first_r;
    stable_nxt = stable_r;
    lrun_nxt   = lrun_r;
    lcount_nxt = lcount_r;
    armed_nxt  = armed_r;
    v_long     = 1'b0;
    v_btn      = 1'b0;
    v_sw       = 1'b0;
    scan       = 1'b0;

    // long-press timer advances first
    lc_inc = count_up(lcount_r);
    if (lrun_r) begin
      lcount_nxt = lc_inc;
      if (lc_inc >= limit_of(long_ticks_r)) begin
        lrun_nxt  = 1'b0;
        armed_nxt = 1'b0;
        v_long    = 1'b1;
      end
    end

    bc_inc = count_up(bcount_r);
    if (first_r) begin
      // silent first scan
      first_nxt  = 1'b0;
      stable_nxt = keys;
    end else if (window_r) begin
      bcount_nxt = bc_inc;
      scan       = (bc_inc >= limit_of(bounce_ticks_r));
    end else if (((in_pin_levels ^ prev_r) & KEY_MASK) != '0) begin
      window_nxt = 1'b1;
      bcount_nxt = '0;
    end

    // debounced scan
    if (scan) begin
      window_nxt = 1'b0;
      if (((released & ~sw) != '0) && armed_nxt) begin
        lrun_nxt = 1'b0;
      end
      if (btn_pressed && !lrun_nxt) begin
        lrun_nxt   = 1'b1;
        armed_nxt  = 1'b1;
        lcount_nxt = '0;
      end
      v_btn      = btn_pressed;
      v_sw       = ((pressed | released) & sw) != '0;
      stable_nxt = keys;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '1;
      window_r <= 1'b0;
      bcount_r <= '0;
      first_r  <= 1'b1;
      stable_r <= '0;
      lrun_r   <= 1'b0;
      lcount_r <= '0;
      armed_r  <= 1'b0;
    end else if (accept) begin
      prev_r   <= prev_nxt;
      window_r <= window_nxt;
      bcount_r <= bcount_nxt;
      first_r  <= first_nxt;
      stable_r <= stable_nxt;
      lrun_r   <= lrun_nxt;
      lcount_r <= lcount_nxt;
      armed_r  <= armed_nxt;
    end
  end

  // result words and their queue slots
  word_t      w_long, w_btn, w_sw;
  logic [1:0] a_btn, a_sw;
  logic [2:0] n_push;

  always_comb begin
    w_long = '{kind: EV_LONG, down: stable_r, changed: stable_r,
               last: !(v_btn || v_sw)};
    w_btn  = '{kind: EV_BUTTON, down: keys, changed: changed, last: !v_sw};
    w_sw   = '{kind: EV_SWITCH, down: keys, changed: changed, last: 1'b1};
    a_btn  = wptr_r + 2'(v_long);
    a_sw   = wptr_r + 2'(v_long) + 2'(v_btn);
    n_push = accept ? (3'(v_long) + 3'(v_btn) + 3'(v_sw)) : 3'd0;
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (v_long) q_r[wptr_r] <= w_long;
      if (v_btn)  q_r[a_btn]  <= w_btn;
      if (v_sw)   q_r[a_sw]   <= w_sw;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      qcnt_r <= '0;
    end else begin
      wptr_r <= wptr_r + n_push[1:0];
      rptr_r <= rptr_r + 2'(pop);
      qcnt_r <= after_pop + n_push;
    end
  end

  // queue head drives the result ports
  assign out_event_kind   = q_r[rptr_r].kind;
  assign out_keys_down    = q_r[rptr_r].down;
  assign out_keys_changed = q_r[rptr_r].changed;
  assign out_last         = q_r[rptr_r].last;

endmodule

// ===== tb/sv/key_event_monitor.sv =====
module key_event_monitor import dks_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [PIN_W-1:0] in_pin_levels,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       out_event_kind,
  input  logic [PIN_W-1:0] out_keys_down,
  input  logic [PIN_W-1:0] out_keys_changed,
  input  logic             out_last,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  input  logic             pready,
  output int               fail_count,
  output int               pending
);

  // register copies
  logic [TICK_REG_W-1:0] bounce_reg;
  logic [TICK_REG_W-1:0] hold_reg;
  logic [PIN_W-1:0]      switch_reg;

  // scanner state
  logic [PIN_W-1:0] last_pins;
  logic [PIN_W-1:0] stable;
  logic             window;
  logic             first_scan;
  logic             timer_on;
  logic             armed;
  cnt_t             window_cnt;
  cnt_t             timer_cnt;

  word_t expected_events[$];
  int    errs = 0;

  // tick register to counter threshold, zero behaves as one
  function automatic cnt_t tick_limit(input logic [TICK_REG_W-1:0] t);
    return (t == '0) ? cnt_t'(1) : cnt_t'(t);
  endfunction

  // counter step that sticks at all ones
  function automatic cnt_t bump(input cnt_t c);
    return (&c) ? c : c + cnt_t'(1);
  endfunction

  function automatic word_t make_word(input event_kind_t kind, input logic [PIN_W-1:0] down,
                                      input logic [PIN_W-1:0] changed);
    word_t w;
    w.kind    = kind;
    w.down    = down;
    w.changed = changed;
    w.last    = 1'b0;
    return w;
  endfunction

  // advance the scanner by one tick and queue the events it raises
  task automatic scan_tick(input logic [PIN_W-1:0] pins);
    logic [PIN_W-1:0] keys, pressed, released, changed, sw;
    word_t            evs[3];
    int               n;
    n    = 0;
    keys = ~pins & KEY_MASK;

    // long-press timer runs first
    if (timer_on) begin
      timer_cnt = bump(timer_cnt);
      if (timer_cnt >= tick_limit(hold_reg)) begin
        timer_on = 1'b0;
        armed    = 1'b0;
        evs[n]   = make_word(EV_LONG, stable, stable);
        n++;
      end
    end

    if (first_scan) begin
      // silent scan right after reset
      first_scan = 1'b0;
      stable     = keys;
    end else if (window) begin
      window_cnt = bump(window_cnt);
      if (window_cnt >= tick_limit(bounce_reg)) begin
        sw       = switch_reg & KEY_MASK;
        pressed  = keys & ~stable;
        released = stable & ~keys;
        changed  = keys ^ stable;
        window   = 1'b0;
        // button release cancels an armed timer before a new press restarts it
        if (((released & ~sw) != '0) && armed) begin
          timer_on = 1'b0;
        end
        if ((pressed & ~sw) != '0) begin
          if (!timer_on) begin
            timer_on  = 1'b1;
            armed     = 1'b1;
            timer_cnt = '0;
          end
          evs[n] = make_word(EV_BUTTON, keys, changed);
          n++;
        end
        if (((pressed | released) & sw) != '0) begin
          evs[n] = make_word(EV_SWITCH, keys, changed);
          n++;
        end
        stable = keys;
      end
    end else if (((pins ^ last_pins) & KEY_MASK) != '0) begin
      window     = 1'b1;
      window_cnt = '0;
    end
    last_pins = pins;

    if (n > 0) begin
      evs[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      expected_events.push_back(evs[i]);
    end
  endtask

  always @(posedge clk) begin
    word_t want;
    if (!rst_n) begin
      bounce_reg = TICK_REG_W'(50);
      hold_reg   = TICK_REG_W'(1000);
      switch_reg = PIN_W'(12);
      last_pins  = '1;
      stable     = '0;
      window     = 1'b0;
      first_scan = 1'b1;
      timer_on   = 1'b0;
      armed      = 1'b0;
      window_cnt = '0;
      timer_cnt  = '0;
      expected_events.delete();
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BOUNCE: bounce_reg = pwdata[TICK_REG_W-1:0];
          REG_LONG:   hold_reg   = pwdata[TICK_REG_W-1:0];
          REG_SWMASK: switch_reg = pwdata[PIN_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        scan_tick(in_pin_levels);
      end

      // compare each event word with the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_events.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("unexpected event word: kind %0d down %h changed %h last %b",
                     out_event_kind, out_keys_down, out_keys_changed, out_last);
          end
        end else begin
          want = expected_events.pop_front();
          if (out_event_kind !== want.kind || out_keys_down !== want.down ||
              out_keys_changed !== want.changed || out_last !== want.last) begin
            errs++;
            if (errs <= 10) begin
              $display({"event mismatch: expected kind %0d down %h changed %h last %b,",
                        " got kind %0d down %h changed %h last %b"},
                       want.kind, want.down, want.changed, want.last,
                       out_event_kind, out_keys_down, out_keys_changed, out_last);
            end
          end
        end
      end
    end
    fail_count <= errs;
    pending    <= expected_events.size();
  end

endmodule

// ===== tb/sv/tb_debounced_key_scanner.sv =====
module tb_debounced_key_scanner;
  import dks_pkg::*;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic [PIN_W-1:0] in_pin_levels = '1;
  logic             out_stall     = 1'b0;
  logic             psel          = 1'b0;
  logic             penable       = 1'b0;
  logic             pwrite        = 1'b0;
  logic [3:0]       paddr         = '0;
  logic [31:0]      pwdata        = '0;

  logic             in_stall;
  logic             out_valid;
  logic [1:0]       out_event_kind;
  logic [PIN_W-1:0] out_keys_down;
  logic [PIN_W-1:0] out_keys_changed;
  logic             out_last;
  logic [31:0]      prdata;
  logic             pready;

  int fail_count;
  int pending;

  // idle rates in percent
  int gap_pct   = 0;
  int stall_pct = 0;

  logic [PIN_W-1:0]      levels     = '1;
  logic [TICK_REG_W-1:0] cur_bounce = TICK_REG_W'(50);

  // directed ticks, active low pins, run with bounce 0 and long press 3
  logic [PIN_W-1:0] directed_pins[$] = '{
    8'h00,               // silent scan with every key down
    8'hFF, 8'hFF,        // release all, switches move
    8'hFE, 8'hFE,        // button press starts the timer
    8'hFC, 8'hFC,        // second press while the timer runs
    8'hFC,               // long press fires
    8'hFF, 8'hFF,        // buttons released, timer already idle
    8'hFE, 8'hFE, 8'hFE,
    8'hFF, 8'hFF,        // long press and release scan in one tick
    8'hFE, 8'hFE,
    8'hFD, 8'hFD,        // release and press in one scan restarts the timer
    8'hFD,
    8'h7D, 8'h6C,        // long press, button and switch in one tick
    8'h00, 8'h00,        // buttons and switches together
    8'hFF
  };

  debounced_key_scanner DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pin_levels    (in_pin_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_keys_down    (out_keys_down),
    .out_keys_changed (out_keys_changed),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  key_event_monitor events_mon (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pin_levels    (in_pin_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_kind   (out_event_kind),
    .out_keys_down    (out_keys_down),
    .out_keys_changed (out_keys_changed),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // random backpressure on the event side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // one tick word, with optional idle cycles ahead of it
  task automatic send_tick(input logic [PIN_W-1:0] pins);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pin_levels <= pins;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait until every predicted event word has come out
  task automatic drain_events();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [TICK_REG_W-1:0] bounce, input logic [TICK_REG_W-1:0] hold,
                          input logic [PIN_W-1:0] mask);
    write_reg(REG_BOUNCE, 32'(bounce));
    write_reg(REG_LONG, 32'(hold));
    write_reg(REG_SWMASK, 32'(mask));
    cur_bounce = bounce;
  endtask

  // mostly settled key changes with a little bounce, some pure noise
  task automatic random_ticks(input int n);
    int               sent;
    int               hold;
    int               lim;
    logic [PIN_W-1:0] target;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) == 0) begin
        send_tick(PIN_W'($urandom));
        sent++;
      end else begin
        case ($urandom_range(3))
          0:       target = levels ^ (PIN_W'(1) << $urandom_range(PIN_W-1));
          1:       target = PIN_W'($urandom);
          2:       target = levels ^ PIN_W'($urandom);
          default: target = levels;
        endcase
        repeat ($urandom_range(2)) begin
          send_tick(PIN_W'($urandom));
          sent++;
        end
        lim  = (cur_bounce == 0) ? 1 : ((cur_bounce > 6) ? 6 : int'(cur_bounce));
        hold = lim + $urandom_range(6);
        repeat (hold) begin
          send_tick(target);
          sent++;
        end
        levels = target;
      end
    end
  endtask

  task automatic run_phase(input int gap, input int stall, input logic [TICK_REG_W-1:0] bounce,
                           input logic [TICK_REG_W-1:0] hold, input logic [PIN_W-1:0] mask,
                           input int n);
    drain_events();
    set_regs(bounce, hold, mask);
    gap_pct   = gap;
    stall_pct = stall;
    random_ticks(n);
  endtask

  // stimulus
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs('0, TICK_REG_W'(3), 8'hF0);
    foreach (directed_pins[i]) begin
      send_tick(directed_pins[i]);
    end
    levels = directed_pins[directed_pins.size()-1];

    run_phase(21, 73, TICK_REG_W'(2), TICK_REG_W'(6), 8'h0C, 70);
    run_phase(73, 21, TICK_REG_W'(1), '0, PIN_W'($urandom), 70);
    run_phase(0, 0, '1, '1, 8'h00, 10);
    run_phase(0, 0, TICK_REG_W'(3), TICK_REG_W'(9), 8'hFF, 25);
    run_phase(0, 0, TICK_REG_W'(1), TICK_REG_W'(4), PIN_W'($urandom), 35);

    drain_events();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS debounced_key_scanner");
    end else begin
      $display("FAIL debounced_key_scanner");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL debounced_key_scanner");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dks_pkg.sv
hw/rtl/debounced_key_scanner.sv
tb/sv/key_event_monitor.sv
tb/sv/tb_debounced_key_scanner.sv
